@@ src/scaled_multiply_divide_hold_core_defines.svh @@
// ----------------------------------------------------------------------------
// scaled multiply divide hold core - assertion macros
// shared concurrent assertion wrappers used by the rtl files
// ----------------------------------------------------------------------------
`ifndef SCALED_MULTIPLY_DIVIDE_HOLD_CORE_DEFINES_SVH
`define SCALED_MULTIPLY_DIVIDE_HOLD_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define SMDH_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define SMDH_ASSERT(lbl, prop, msg) \
  `SMDH_ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ src/smdh_pkg.sv @@
// ----------------------------------------------------------------------------
// smdh_pkg
// types, constants and helper functions of the scaled multiply divide core
// ----------------------------------------------------------------------------
`default_nettype none

package smdh_pkg;

  // field widths
  localparam int unsigned CH_W    = 4;
  localparam int unsigned VOLT_W  = 24;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned MODE_W  = 2;

  // serial datapath widths
  localparam int unsigned MCAND_W  = 27;  // |a| * 10 fits
  localparam int unsigned MPLIER_W = 24;  // |b| up to 2^23
  localparam int unsigned PROD_W   = 51;  // mcand * mplier
  localparam int unsigned PSUM_W   = PROD_W + 1;
  localparam int unsigned DIV_N_W  = 44;
  localparam int unsigned DIV_D_W  = 24;
  localparam int unsigned PDEN_W   = 7;   // product divisor up to 100
  localparam int unsigned AOS_W    = 28;  // a * 10, signed
  localparam int unsigned FRAC_W   = 16;

  localparam logic [VOLT_W-1:0]  ONE_VOLT   = 24'h01_0000;
  localparam logic signed [OUT_W-1:0] CLIP_POS = 32'sd655360;
  localparam logic signed [OUT_W-1:0] CLIP_NEG = -32'sd655360;
  localparam logic [DIV_N_W-1:0] SAT_POS_Q  = 44'h0_7FFF_FFFF;
  localparam logic [DIV_N_W-1:0] SAT_NEG_Q  = 44'h0_8000_0000;
  localparam logic [OUT_W-1:0]   SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0]   SAT_NEG    = 32'h8000_0000;

  // scale mode codes, code 3 behaves as x10
  localparam logic [MODE_W-1:0] MODE_X1  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X5  = 2'd1;

  typedef enum logic [1:0] {
    CFG_A_SCALE   = 2'd0,
    CFG_B_SCALE   = 2'd1,
    CFG_OUT_SCALE = 2'd2,
    CFG_CLIP      = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PDIV = 5'b00100,
    ST_QDIV = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic                start;
    logic [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // input divisor of a scale mode
  function automatic logic [3:0] den_code(input logic [MODE_W-1:0] mode);
    logic [3:0] r;
    case (mode)
      MODE_X1: r = 4'd1;
      MODE_X5: r = 4'd5;
      default: r = 4'd10;
    endcase
    return r;
  endfunction

  // unsigned magnitude times the output factor
  function automatic logic [MCAND_W-1:0] times_os(input logic [VOLT_W-1:0] x,
                                                  input logic [MODE_W-1:0] mode);
    logic [MCAND_W-1:0] x27;
    logic [MCAND_W-1:0] r;
    x27 = MCAND_W'(x);
    case (mode)
      MODE_X1: r = x27;
      MODE_X5: r = (x27 << 2) + x27;
      default: r = (x27 << 3) + (x27 << 1);
    endcase
    return r;
  endfunction

  // signed sample times the output factor
  function automatic logic signed [AOS_W-1:0] times_os_s(input logic signed [VOLT_W-1:0] x,
                                                         input logic [MODE_W-1:0] mode);
    logic signed [AOS_W-1:0] xe;
    logic signed [AOS_W-1:0] r;
    xe = AOS_W'(x);
    case (mode)
      MODE_X1: r = xe;
      MODE_X5: r = (xe <<< 2) + xe;
      default: r = (xe <<< 3) + (xe <<< 1);
    endcase
    return r;
  endfunction

  // apply sign to a rounded magnitude and saturate to 32 bits
  function automatic logic [OUT_W-1:0] sat_round(input logic neg,
                                                 input logic [DIV_N_W-1:0] q);
    logic [OUT_W:0]   negq;
    logic [OUT_W-1:0] r;
    negq = '0 - q[OUT_W:0];
    if (neg) begin
      r = (q > SAT_NEG_Q) ? SAT_NEG : negq[OUT_W-1:0];
    end else begin
      r = (q > SAT_POS_Q) ? SAT_POS : q[OUT_W-1:0];
    end
    return r;
  endfunction

  // optional clamp to plus or minus 10 V
  function automatic logic signed [OUT_W-1:0] clip10(input logic signed [OUT_W-1:0] v,
                                                     input logic en);
    logic signed [OUT_W-1:0] r;
    r = v;
    if (en && (v > CLIP_POS)) begin
      r = CLIP_POS;
    end else if (en && (v < CLIP_NEG)) begin
      r = CLIP_NEG;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/smdh_serial_mul.sv @@
// ----------------------------------------------------------------------------
// smdh_serial_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smdh_serial_mul
  import smdh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mul_req_t          req_i,
  output unit_stat_t             stat_o,
  output logic [PROD_W-1:0]      product_o
);

  localparam int unsigned ACC_W = MCAND_W + 1 + MPLIER_W;
  localparam int unsigned CNT_W = $clog2(MPLIER_W);

  logic [ACC_W-1:0]   acc_q;
  logic [MCAND_W-1:0] mcand_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [MCAND_W:0]   sum;

  // high half plus multiplicand when the current low bit is set
  always_comb begin
    sum = acc_q[ACC_W-1:MPLIER_W];
    if (acc_q[0]) begin
      sum = acc_q[ACC_W-1:MPLIER_W] + (MCAND_W+1)'(mcand_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MPLIER_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q   <= {(MCAND_W+1)'(0), req_i.mplier};
      mcand_q <= req_i.mcand;
    end else if (busy_q) begin
      acc_q <= {1'b0, sum, acc_q[MPLIER_W-1:1]};
    end
  end

  assign product_o   = acc_q[PROD_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

@@ src/smdh_serial_div.sv @@
// ----------------------------------------------------------------------------
// smdh_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smdh_serial_div
  import smdh_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire div_req_t           req_i,
  output unit_stat_t              stat_o,
  output logic [DIV_N_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W-1:0] den_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DIV_D_W+1:0] trial;

  // shifted remainder minus divisor, top bit is the borrow
  assign trial = {1'b0, rem_q, quo_q[DIV_N_W-1]} - (DIV_D_W+2)'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[DIV_D_W+1]) begin
        rem_q <= trial[DIV_D_W-1:0];
        quo_q <= {quo_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DIV_D_W-2:0], quo_q[DIV_N_W-1]};
        quo_q <= {quo_q[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

@@ src/smdh_hold_store.sv @@
// ----------------------------------------------------------------------------
// smdh_hold_store
// per-channel held quotient memory, reads as zero until written
// ----------------------------------------------------------------------------
`default_nettype none

module smdh_hold_store
  import smdh_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [CH_W-1:0]  rd_ch_i,
  output logic [OUT_W-1:0]      rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [CH_W-1:0]  wr_ch_i,
  input  wire logic [OUT_W-1:0] wr_data_i
);

  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_NUM = 2 ** CH_W;

  logic [IDX_W-1:0]  idx_map [CH_NUM];
  logic [OUT_W-1:0]  mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [OUT_W-1:0]  rd_data_q;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;

  // channel index wraps modulo the store depth
  for (genvar g = 0; g < CH_NUM; g++) begin : g_map
    localparam int unsigned M = g % CHANNELS;
    assign idx_map[g] = M[IDX_W-1:0];
  end

  assign rd_idx = idx_map[rd_ch_i];
  assign wr_idx = idx_map[wr_ch_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_idx] ? mem_q[rd_idx] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ src/scaled_multiply_divide_hold_core.sv @@
// ----------------------------------------------------------------------------
// scaled_multiply_divide_hold_core
// scaled product and held quotient of two control-voltage channels
// ----------------------------------------------------------------------------
// One transaction carries one channel of a polyphonic frame. The block returns
// the scaled product (A/as)*(B/bs)*os and the quotient A/B*os in Q16.16, both
// rounded to nearest with ties away from zero, saturated, and optionally
// clipped to +/-10 V. A missing input counts as 1 V; with B missing the
// quotient is A*os, and a zero divisor repeats that channel's held quotient
// (zero after reset). One transaction is worked on at a time, and a quotient
// is divided only when B is present and not zero. The work is done by the
// bit-serial shift-add multiplier (24 steps) and the one-bit restoring
// divider, which runs 44 steps for the product rounding and again for the
// quotient. A finished result waits in the output register while the next
// transaction is accepted. Configuration writes are taken at any time and
// should only be issued while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scaled_multiply_divide_hold_core_defines.svh"

module scaled_multiply_divide_hold_core
  import smdh_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // a_volts, b_volts, a_count, b_count
  input  wire logic [3:0]  s_axis_tuser_i,   // channel
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // product_volts, quotient_volts
  output logic [3:0]       m_axis_tuser_o,   // out_channel
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [1:0]  cfg_data_i
);

  // configuration registers
  logic [MODE_W-1:0] a_mode_q;
  logic [MODE_W-1:0] b_mode_q;
  logic [MODE_W-1:0] o_mode_q;
  logic              clip_en_q;

  // control
  state_e state_q, state_d;
  logic   in_accept;
  logic   out_load;

  // unpacked input transaction
  logic [CH_W-1:0]          in_ch;
  logic signed [VOLT_W-1:0] in_a;
  logic signed [VOLT_W-1:0] in_b;
  logic [COUNT_W-1:0]       in_ac;
  logic [COUNT_W-1:0]       in_bc;
  logic                     a_on;
  logic                     b_on;
  logic [VOLT_W-1:0]        a_mag;
  logic [VOLT_W-1:0]        b_mag;
  logic [3:0]               a_den;
  logic [3:0]               b_den;

  // per-transaction working registers
  logic [CH_W-1:0]         ch_q;
  logic                    neg_q;
  logic                    b_on_q;
  logic                    b_zero_q;
  logic [MCAND_W-1:0]      mcand_q;
  logic [VOLT_W-1:0]       bmag_q;
  logic signed [AOS_W-1:0] aos_q;
  logic [PDEN_W-1:0]       pden_q;
  logic [OUT_W-1:0]        prod_q;
  logic [OUT_W-1:0]        quot_q;

  // output register
  logic             m_tvalid_q;
  logic [OUT_W-1:0] m_prod_q;
  logic [OUT_W-1:0] m_quot_q;
  logic [CH_W-1:0]  m_ch_q;

  // serial units and held store
  mul_req_t          mul_req;
  unit_stat_t        mul_stat;
  logic [PROD_W-1:0] mul_product;
  div_req_t          div_req;
  unit_stat_t        div_stat;
  logic [DIV_N_W-1:0] div_quot;
  logic [OUT_W-1:0]  held_rd;
  logic              st_wr_en;
  logic [PSUM_W-1:0] pdiv_sum;
  logic [OUT_W-1:0]  fin_quot;

  // --------------------------------------------------------------------------
  // configuration port, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_mode_q  <= MODE_X1;
      b_mode_q  <= MODE_X1;
      o_mode_q  <= MODE_X1;
      clip_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_A_SCALE:   a_mode_q  <= cfg_data_i;
        CFG_B_SCALE:   b_mode_q  <= cfg_data_i;
        CFG_OUT_SCALE: o_mode_q  <= cfg_data_i;
        CFG_CLIP:      clip_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input transaction decode
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign in_ch = s_axis_tuser_i;
  assign in_a  = $signed(s_axis_tdata_i[23:0]);
  assign in_b  = $signed(s_axis_tdata_i[47:24]);
  assign in_ac = s_axis_tdata_i[52:48];
  assign in_bc = s_axis_tdata_i[57:53];

  // a single-channel input is shared by every channel
  assign a_on = ({1'b0, in_ch} < in_ac) || (in_ac == COUNT_W'(1));
  assign b_on = ({1'b0, in_ch} < in_bc) || (in_bc == COUNT_W'(1));

  assign a_mag = in_a[VOLT_W-1] ? (VOLT_W'(0) - s_axis_tdata_i[23:0]) : s_axis_tdata_i[23:0];
  assign b_mag = in_b[VOLT_W-1] ? (VOLT_W'(0) - s_axis_tdata_i[47:24]) : s_axis_tdata_i[47:24];

  // an absent input is 1 V and is not scaled
  assign a_den = den_code(a_on ? a_mode_q : MODE_X1);
  assign b_den = den_code(b_on ? b_mode_q : MODE_X1);

  // multiplicand (A or 1 V) * os also serves as the quotient numerator
  assign mul_req.start  = in_accept;
  assign mul_req.mcand  = times_os(a_on ? a_mag : ONE_VOLT, o_mode_q);
  assign mul_req.mplier = b_on ? b_mag : ONE_VOLT;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q     <= in_ch;
      neg_q    <= (a_on && in_a[VOLT_W-1]) ^ (b_on && in_b[VOLT_W-1]);
      b_on_q   <= b_on;
      b_zero_q <= (in_b == '0);
      mcand_q  <= mul_req.mcand;
      bmag_q   <= b_mag;
      aos_q    <= times_os_s(in_a, o_mode_q);
      pden_q   <= {3'b000, a_den} * {3'b000, b_den};
    end
  end

  // --------------------------------------------------------------------------
  // serial arithmetic
  // --------------------------------------------------------------------------
  smdh_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .stat_o    (mul_stat),
    .product_o (mul_product)
  );

  // product rounding: floor((num + d*2^15) / 2^16) then divide by d
  assign pdiv_sum = {1'b0, mul_product} + PSUM_W'({pden_q, 15'b0});

  always_comb begin
    div_req = '0;
    if ((state_q == ST_MUL) && mul_stat.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'(pdiv_sum[PSUM_W-1:FRAC_W]);
      div_req.divisor  = DIV_D_W'(pden_q);
    end else if ((state_q == ST_PDIV) && div_stat.done && b_on_q && !b_zero_q) begin
      // quotient: (|A or 1 V| * os * 2^16 + |B|/2) / |B|
      div_req.start    = 1'b1;
      div_req.dividend = DIV_N_W'({mcand_q, 16'h0000}) + DIV_N_W'(bmag_q[VOLT_W-1:1]);
      div_req.divisor  = bmag_q;
    end
  end

  smdh_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PDIV) && div_stat.done) begin
      prod_q <= clip10(sat_round(neg_q, div_quot), clip_en_q);
    end
    if ((state_q == ST_QDIV) && div_stat.done) begin
      quot_q <= clip10(sat_round(neg_q, div_quot), clip_en_q);
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_d = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (div_stat.done) begin
          state_d = (b_on_q && !b_zero_q) ? ST_QDIV : ST_FIN;
        end
      end
      ST_QDIV: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // held quotient store, read on acceptance and written back on completion when B is present
  // --------------------------------------------------------------------------
  smdh_hold_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_ch_i   (in_ch),
    .rd_data_o (held_rd),
    .wr_en_i   (st_wr_en),
    .wr_ch_i   (ch_q),
    .wr_data_i (fin_quot)
  );

  // zero divisor re-clips the held value, absent b passes a * os
  always_comb begin
    if (b_on_q) begin
      fin_quot = b_zero_q ? clip10(held_rd, clip_en_q) : quot_q;
    end else begin
      fin_quot = clip10(OUT_W'(aos_q), clip_en_q);
    end
  end

  assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_axis_tready_i);
  assign st_wr_en = out_load && b_on_q;

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_prod_q <= prod_q;
      m_quot_q <= fin_quot;
      m_ch_q   <= ch_q;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {m_quot_q, m_prod_q};
  assign m_axis_tuser_o  = m_ch_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SMDH_ASSERT(a_units_idle, s_axis_tready_o |-> !mul_stat.busy && !div_stat.busy, "serial unit busy while accepting")
  `SMDH_ASSERT(a_qdiv_needed, (state_q == ST_QDIV) |-> b_on_q && !b_zero_q, "quotient division without a divisor")
  `SMDH_ASSERT(a_result_from_fin, $rose(m_tvalid_q) |-> $past(state_q == ST_FIN), "result shown outside completion")
  `SMDH_ASSERT(a_clip_range, (m_tvalid_q && clip_en_q) |-> ($signed(m_prod_q) <= CLIP_POS) && ($signed(m_prod_q) >= CLIP_NEG) && ($signed(m_quot_q) <= CLIP_POS) && ($signed(m_quot_q) >= CLIP_NEG), "clipped result out of range")

endmodule

`default_nettype wire

@@ tb/tb_scaled_multiply_divide_hold_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scaled_multiply_divide_hold_core
// self-checking testbench of the scaled multiply / divide core with held quotient
// ----------------------------------------------------------------------------
// Channel transactions go in on the slave stream and a predictor works out the
// product, the quotient and the per-channel held value for each one. Each
// output transaction is checked field by field against the oldest prediction.
// A directed pass covers the corners: full-scale samples, saturation, zero
// divisors, absent inputs, broadcast and out-of-range channel counts, rounding
// ties, every scale mode and clipping. Random polyphonic frames then run
// under several register settings, with bursty input and output back-pressure.
// ----------------------------------------------------------------------------
module tb_scaled_multiply_divide_hold_core;
  import smdh_pkg::*;

  localparam int unsigned    CHANNEL_COUNT = 16;
  localparam int unsigned    CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned    DRAIN_CYCLES  = 150;   // longer than one item takes
  localparam int unsigned    PHASES        = 8;
  localparam int unsigned    PHASE_ITEMS   = 225;
  localparam longint         ONE_VOLT_Q16  = 65536;
  localparam int             CLIP_Q16      = 655360;
  // scale codes not named in the package
  localparam logic [MODE_W-1:0] MODE_X10   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;  // treated as x10

  typedef enum int {RX_ALWAYS, RX_EVERY_THIRD, RX_COIN, RX_LONG_STALLS} rx_mode_e;

  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic signed [VOLT_W-1:0]  a_volts;
    logic signed [VOLT_W-1:0]  b_volts;
    logic [COUNT_W-1:0]        a_count;
    logic [COUNT_W-1:0]        b_count;
  } channel_item_t;

  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic signed [OUT_W-1:0]   product;
    logic signed [OUT_W-1:0]   quotient;
  } channel_result_t;

  // dut ports, every input known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;
  logic [3:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = '0;
  logic [1:0]  cfg_data_i      = '0;

  // predictor copy of the registers and the held quotient store
  logic [MODE_W-1:0]       a_mode;
  logic [MODE_W-1:0]       b_mode;
  logic [MODE_W-1:0]       o_mode;
  logic                    clip_on;
  logic signed [OUT_W-1:0] held_quotient_q16 [CHANNEL_COUNT];

  channel_result_t results_due[$];

  int unsigned cycle_count        = 0;
  int unsigned mismatch_count     = 0;
  int unsigned items_sent         = 0;
  int unsigned results_checked    = 0;
  int unsigned settings_applied   = 0;
  int unsigned zero_divisor_holds = 0;
  int unsigned burst_left         = 0;

  scaled_multiply_divide_hold_core #(
    .CHANNELS (CHANNEL_COUNT)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // watchdog, also the time base of the output stall pattern
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // input divisor and output factor share one mapping: 1, 5, else 10
  function automatic longint unsigned scale_factor(input logic [MODE_W-1:0] mode);
    longint unsigned f;
    case (mode)
      MODE_X1: f = 1;
      MODE_X5: f = 5;
      default: f = 10;
    endcase
    return f;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // nearest Q16.16 step, ties away from zero, saturated to 32 bits
  function automatic logic signed [OUT_W-1:0] round_to_q16(input bit neg,
                                                           input longint unsigned num,
                                                           input longint unsigned den);
    longint unsigned q;
    q = (num + den / 2) / den;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return OUT_W'(64'd0 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return OUT_W'(q);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_10v(input logic signed [OUT_W-1:0] v);
    if (clip_on && v > CLIP_Q16) return CLIP_Q16;
    if (clip_on && v < -CLIP_Q16) return -CLIP_Q16;
    return v;
  endfunction

  // expected result of one channel transaction, updates the held store
  function automatic channel_result_t compute_channel_result(input channel_item_t it);
    channel_result_t r;
    longint          a;
    longint          b;
    longint          num_v;
    longint unsigned os;
    longint unsigned a_num;
    longint unsigned a_den;
    longint unsigned b_num;
    longint unsigned b_den;
    bit              a_on;
    bit              b_on;
    bit              neg;
    a     = $signed(it.a_volts);
    b     = $signed(it.b_volts);
    a_on  = (it.channel < it.a_count) || (it.a_count == 1);
    b_on  = (it.channel < it.b_count) || (it.b_count == 1);
    os    = scale_factor(o_mode);
    // an absent input is a plain 1 V, not scaled
    a_num = a_on ? magnitude(a) : ONE_VOLT_Q16;
    a_den = a_on ? scale_factor(a_mode) : 1;
    b_num = b_on ? magnitude(b) : ONE_VOLT_Q16;
    b_den = b_on ? scale_factor(b_mode) : 1;
    neg   = (a_on && a < 0) != (b_on && b < 0);
    r.channel = it.channel;
    r.product = clamp_10v(round_to_q16(neg, a_num * b_num * os,
                                       a_den * b_den * ONE_VOLT_Q16));
    if (b_on) begin
      if (b != 0) begin
        num_v = a_on ? a : ONE_VOLT_Q16;
        held_quotient_q16[it.channel] =
          round_to_q16((num_v < 0) != (b < 0), magnitude(num_v) * ONE_VOLT_Q16 * os,
                       magnitude(b));
      end else begin
        zero_divisor_holds++;
      end
      // held value is re-clipped and stored back even when it is only repeated
      held_quotient_q16[it.channel] = clamp_10v(held_quotient_q16[it.channel]);
      r.quotient = held_quotient_q16[it.channel];
    end else begin
      // b absent: a times the output factor, even with a absent too
      r.quotient = clamp_10v(OUT_W'(a * longint'(os)));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // output side: compare each transaction, then pick the next ready value
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_ALWAYS;
  int unsigned stall_run = 0;

  always @(posedge clk_i) begin : check_results
    channel_result_t want;
    logic signed [OUT_W-1:0] got_product;
    logic signed [OUT_W-1:0] got_quotient;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_product  = m_axis_tdata_o[31:0];
      got_quotient = m_axis_tdata_o[63:32];
      if (results_due.size() == 0) begin
        $error("unexpected result on channel %0d: product %0d, quotient %0d",
               m_axis_tuser_o, got_product, got_quotient);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (m_axis_tuser_o !== want.channel) begin
          $error("out_channel mismatch: expected %0d, got %0d", want.channel,
                 m_axis_tuser_o);
          mismatch_count++;
        end
        if (got_product !== want.product) begin
          $error("product_volts mismatch on channel %0d: expected %0d, got %0d",
                 want.channel, want.product, got_product);
          mismatch_count++;
        end
        if (got_quotient !== want.quotient) begin
          $error("quotient_volts mismatch on channel %0d: expected %0d, got %0d",
                 want.channel, want.quotient, got_quotient);
          mismatch_count++;
        end
      end
    end
    // stall pattern is picked anew at random, periodically
    if (cycle_count % 300 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_ALWAYS:      m_axis_tready_i <= 1'b1;
      RX_EVERY_THIRD: m_axis_tready_i <= (cycle_count % 3) != 0;
      RX_COIN:        m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 40);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // input side and register writes
  // --------------------------------------------------------------------------

  // bursts of random length with random gaps, some long enough to land the
  // next transaction on any phase of the core's work
  task automatic pace_sender();
    int unsigned gap;
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30)      gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 8);
    else                gap = $urandom_range(9, 140);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
  endtask

  // one input transaction; tdata holds a, b, a_count, b_count from bit 0 up
  task automatic send_item(input channel_item_t it);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, it.b_count, it.a_count, it.b_volts, it.a_volts};
    s_axis_tuser_i  <= it.channel;
    do @(posedge clk_i); while (!s_axis_tready_o);
    results_due.push_back(compute_channel_result(it));
    items_sent++;
    pace_sender();
  endtask

  // no input pending, every result delivered and the core ready again
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (results_due.size() != 0 || !s_axis_tready_o) @(posedge clk_i);
  endtask

  // valid stays high across consecutive writes, the caller lowers it
  task automatic write_reg(input cfg_reg_e idx, input logic [1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_A_SCALE:   a_mode  = val;
      CFG_B_SCALE:   b_mode  = val;
      CFG_OUT_SCALE: o_mode  = val;
      CFG_CLIP:      clip_on = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [MODE_W-1:0] a_sel, input logic [MODE_W-1:0] b_sel,
                                input logic [MODE_W-1:0] o_sel, input logic clip);
    wait_idle();
    write_reg(CFG_A_SCALE, a_sel);
    write_reg(CFG_B_SCALE, b_sel);
    write_reg(CFG_OUT_SCALE, o_sel);
    write_reg(CFG_CLIP, {1'b0, clip});
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  function automatic channel_item_t make_item(input int ch, input int a, input int b,
                                              input int ac, input int bc);
    channel_item_t it;
    it.channel = CH_W'(ch);
    it.a_volts = VOLT_W'(a);
    it.b_volts = VOLT_W'(b);
    it.a_count = COUNT_W'(ac);
    it.b_count = COUNT_W'(bc);
    return it;
  endfunction

  // mostly musical voltages, some full-scale corners and raw random words
  function automatic logic signed [VOLT_W-1:0] random_volts();
    logic signed [VOLT_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = 24'sh7F_FFFF;
          1:       v = 24'sh80_0000;
          2:       v = '0;
          3:       v = 24'sd1;
          default: v = -24'sd1;
        endcase
      end
      1, 2, 3: v = VOLT_W'($urandom_range(0, 524288)) - 24'd262144;
      4, 5:    v = VOLT_W'($urandom_range(0, 131072)) - 24'd65536;
      default: v = VOLT_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return CHANNEL_COUNT;
    if (pick < 55) return 1;
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(0, CHANNEL_COUNT);
    return $urandom_range(17, 31);
  endfunction

  // one polyphonic frame: channels in order up to the larger count
  task automatic send_frame();
    int ac;
    int bc;
    int n;
    int b;
    ac = pick_count();
    bc = pick_count();
    n  = (ac > bc) ? ac : bc;
    if (n < 1) n = 1;
    if (n > CHANNEL_COUNT) n = CHANNEL_COUNT;
    for (int ch = 0; ch < n; ch++) begin
      b = ($urandom_range(0, 9) == 0) ? 0 : int'(random_volts());
      send_item(make_item(ch, random_volts(), b, ac, bc));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  task automatic test_special_cases();
    // reset settings: unit scales, no clipping; fresh channels hold zero
    send_item(make_item(2, 65536, 0, 16, 16));
    send_item(make_item(15, -65536, 0, 16, 16));
    send_item(make_item(0, 65536, 131072, 16, 16));
    // full-scale samples give the largest product both ways
    send_item(make_item(1, 8388607, 8388607, 16, 16));
    send_item(make_item(2, -8388608, 8388607, 16, 16));
    // tiny divisor saturates the quotient both ways
    send_item(make_item(3, 8388607, 1, 16, 16));
    send_item(make_item(4, -8388608, 1, 16, 16));
    // zero divisor repeats the saturated value of channel 3
    send_item(make_item(3, 12345, 0, 16, 16));
    // b absent, both absent, a absent
    send_item(make_item(9, -8388608, 65536, 16, 4));
    send_item(make_item(12, 196608, -196608, 3, 5));
    send_item(make_item(4, 327680, -196608, 2, 8));
    // single-channel inputs broadcast, empty and oversized counts
    send_item(make_item(15, -131072, 196608, 1, 1));
    send_item(make_item(0, 65536, 65536, 0, 0));
    send_item(make_item(15, 131072, -65536, 31, 17));
    // rounding ties go away from zero
    send_item(make_item(1, 1, 32768, 16, 16));
    send_item(make_item(1, -1, 32768, 16, 16));
    send_item(make_item(6, 0, -65536, 16, 16));

    // alias scale code and clipping, held value re-clipped on a zero divisor
    apply_settings(MODE_ALIAS, MODE_ALIAS, MODE_ALIAS, 1'b1);
    send_item(make_item(3, 65536, 0, 16, 16));
    send_item(make_item(1, 8388607, 8388607, 16, 16));
    send_item(make_item(9, -8388608, 65536, 16, 4));
    send_item(make_item(5, -131072, 196608, 16, 16));

    apply_settings(MODE_X5, MODE_X5, MODE_X5, 1'b0);
    send_item(make_item(7, 327680, 16384, 16, 16));
    send_item(make_item(8, 8388607, -1, 16, 16));

    apply_settings(MODE_X10, MODE_X1, MODE_X10, 1'b0);
    send_item(make_item(10, 196608, 458752, 16, 16));
    send_item(make_item(4, 0, 0, 16, 16));
  endtask

  task automatic test_random_traffic();
    int unsigned phase_start;
    bit          paused;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       apply_settings(MODE_X1, MODE_X1, MODE_X1, 1'b0);
        1:       apply_settings(MODE_X10, MODE_X10, MODE_X10, 1'b1);
        2:       apply_settings(MODE_ALIAS, MODE_X5, MODE_X1, 1'b1);
        default: apply_settings(MODE_W'($urandom_range(0, 3)), MODE_W'($urandom_range(0, 3)),
                                MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      endcase
      phase_start = items_sent;
      paused      = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // mid-phase the sender waits for the output to run dry
        if (!paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 6) == 0) begin
          // stray channel outside any frame shape
          send_item(make_item($urandom_range(0, 15), $urandom, $urandom,
                              $urandom_range(0, 31), $urandom_range(0, 31)));
        end else begin
          send_frame();
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    a_mode  = MODE_X1;
    b_mode  = MODE_X1;
    o_mode  = MODE_X1;
    clip_on = 1'b0;
    for (int i = 0; i < CHANNEL_COUNT; i++) held_quotient_q16[i] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d channel transactions under %0d register settings, corners then frames",
             items_sent, settings_applied);
    $display("%0d results compared, %0d zero-divisor holds, %0d mismatches",
             results_checked, zero_divisor_holds, mismatch_count);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
